[rtl/core/bchg_pkg.sv]
// ----------------------------------------------------------------------------
// bchg_pkg
// Types, register map and reset values for the button click and hold
// gesture block.
// ----------------------------------------------------------------------------
package bchg_pkg;

  // register map (byte addresses, one 32-bit word per register)
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned TimeWidth = 32;

  typedef enum logic [0:0] {
    REG_DEBOUNCE_MS = 1'b0,
    REG_HOLD_MS     = 1'b1
  } reg_idx_e;

  localparam logic [CfgWidth-1:0] DebounceMsReset = 16'd30;
  localparam logic [CfgWidth-1:0] HoldMsReset     = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_HOLD_START = 2'd1,
    EV_HOLD_END   = 2'd2
  } gesture_e;

  typedef struct packed {
    logic                 raw_pressed;
    logic [TimeWidth-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0] gesture_event;
    logic       mute_on;
    logic       pressed_stable;
  } gesture_t;

endpackage

[rtl/core/button_click_hold_gesture_top.sv]
// ----------------------------------------------------------------------------
// button_click_hold_gesture_top
// Debounces a sampled button level and turns it into click (mute toggle),
// hold-start and hold-end gestures.
// ----------------------------------------------------------------------------
// Every input transaction carries one raw button sample and a free-running
// millisecond timestamp; every one produces exactly one result transaction
// with the gesture event, the mute state and the debounced level after that
// sample. A sample is registered on entry and processed from the input
// register by a single pass of compares and 32-bit modulo subtractions that
// also updates the tracking state, so the block takes one transaction per
// cycle while the output is not stalled. The result is then registered in
// the output register, which decouples the two sides: a new sample is taken
// while a finished result still waits, and only a full pipeline with a
// stalled output stalls the input. The user must write debounce_ms and
// hold_ms over the APB-style port only while the block is idle; the block
// does not enforce it. A zero debounce time accepts a level change in the
// same sample, and a zero hold time fires hold start together with the press.
// ----------------------------------------------------------------------------
module button_click_hold_gesture_top
  import bchg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // sample channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sample_t              in_data_i,

  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gesture_t             out_data_o,

  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CfgWidth-1:0] debounce_ms_q;
  logic [CfgWidth-1:0] hold_ms_q;
  logic                cfg_write;
  reg_idx_e            cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= DebounceMsReset;
      hold_ms_q     <= HoldMsReset;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_DEBOUNCE_MS: debounce_ms_q <= pwdata[CfgWidth-1:0];
        REG_HOLD_MS:     hold_ms_q     <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  // read data, zero-extended to the bus width
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_DEBOUNCE_MS: prdata[CfgWidth-1:0] = debounce_ms_q;
      REG_HOLD_MS:     prdata[CfgWidth-1:0] = hold_ms_q;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control: input register feeds the processing pass, which writes
  // the output register
  // --------------------------------------------------------------------------
  logic    in_valid_q;
  sample_t in_data_q;
  logic    out_valid_q;
  logic    out_free;
  logic    proc_fire;
  logic    in_fire;

  // output register can load when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_fire  = in_valid_q && out_free;
  // input register can load when empty or moving on this cycle
  assign in_stall_o = in_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // tracking state
  // --------------------------------------------------------------------------
  logic                 last_raw_q,     last_raw_d;
  logic [TimeWidth-1:0] raw_since_q,    raw_since_d;
  logic                 stable_q,       stable_d;
  logic [TimeWidth-1:0] press_start_q,  press_start_d;
  logic                 hold_done_q,    hold_done_d;
  logic                 mute_q,         mute_d;
  gesture_e             event_d;

  logic [TimeWidth-1:0] raw_age;
  logic [TimeWidth-1:0] press_age;
  logic                 debounce_ok;
  logic                 level_accept;

  always_comb begin
    last_raw_d    = last_raw_q;
    raw_since_d   = raw_since_q;
    stable_d      = stable_q;
    press_start_d = press_start_q;
    hold_done_d   = hold_done_q;
    mute_d        = mute_q;
    event_d       = EV_NONE;

    // raw level change restarts the debounce interval
    if (in_data_q.raw_pressed != last_raw_q) begin
      last_raw_d  = in_data_q.raw_pressed;
      raw_since_d = in_data_q.now_ms;
    end

    raw_age      = in_data_q.now_ms - raw_since_d;
    debounce_ok  = raw_age >= {{(TimeWidth-CfgWidth){1'b0}}, debounce_ms_q};
    level_accept = debounce_ok && (in_data_q.raw_pressed != stable_q);

    if (level_accept) begin
      stable_d = in_data_q.raw_pressed;
      if (in_data_q.raw_pressed) begin
        // press edge
        press_start_d = in_data_q.now_ms;
        hold_done_d   = 1'b0;
      end else if (hold_done_q) begin
        // release after a hold
        event_d = EV_HOLD_END;
      end else begin
        // short click
        mute_d = !mute_q;
      end
    end

    // hold detection on the updated press start
    press_age = in_data_q.now_ms - press_start_d;
    if (stable_d && !hold_done_d &&
        (press_age >= {{(TimeWidth-CfgWidth){1'b0}}, hold_ms_q})) begin
      hold_done_d = 1'b1;
      event_d     = EV_HOLD_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      raw_since_q   <= '0;
      stable_q      <= 1'b0;
      press_start_q <= '0;
      hold_done_q   <= 1'b0;
      mute_q        <= 1'b0;
    end else if (proc_fire) begin
      last_raw_q    <= last_raw_d;
      raw_since_q   <= raw_since_d;
      stable_q      <= stable_d;
      press_start_q <= press_start_d;
      hold_done_q   <= hold_done_d;
      mute_q        <= mute_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  gesture_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_data_q.gesture_event  <= event_d;
      out_data_q.mute_on        <= mute_d;
      out_data_q.pressed_stable <= stable_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // mute only flips on a debounced release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(mute_q) |-> $fell(stable_q))
    else $error("mute toggled without a release");

  // a hold start leaves the hold flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && (event_d == EV_HOLD_START)) |=> hold_done_q)
    else $error("hold flag not set after hold start");

  // hold start is only reported while pressed, hold end only after release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.gesture_event == EV_HOLD_START)) |->
      out_data_q.pressed_stable)
    else $error("hold start reported while released");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.gesture_event == EV_HOLD_END)) |->
      !out_data_q.pressed_stable)
    else $error("hold end reported while pressed");

  // input only stalls when both pipeline registers are full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button click and hold gesture block.
// ----------------------------------------------------------------------------
// Feeds raw button samples with millisecond timestamps into the sample
// channel and predicts every result transaction with a local model of the
// debounce, click and hold logic. Directed cases come first: register reset
// values, click, hold, contact bounce, timestamp wrap and backward steps,
// zero and maximum times. Then random gesture sequences with bounce, clicks,
// holds, broken presses and noise run under several register settings. Both
// channels idle and stall at random, and some stretches run at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import bchg_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 225;
  localparam int unsigned MaxReported = 10;

  // clock, reset and dut ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  sample_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  gesture_t             out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrWidth-1:0] paddr       = '0;
  logic [DataWidth-1:0] pwdata      = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  // local copy of the gesture state and the registers
  logic                 last_raw_lvl;
  logic [TimeWidth-1:0] raw_change_t;
  logic                 stable_lvl;
  logic [TimeWidth-1:0] press_t0;
  logic                 hold_seen;
  logic                 muted;
  logic [CfgWidth-1:0]  cfg_debounce;
  logic [CfgWidth-1:0]  cfg_hold;

  // results still owed by the dut, oldest first
  gesture_t             gesture_q[$];

  int unsigned          mismatches  = 0;
  int unsigned          cycles      = 0;
  int unsigned          items_sent  = 0;
  int unsigned          stall_left  = 0;
  bit                   gaps_on     = 1'b1;
  bit                   stalls_on   = 1'b1;
  logic [TimeWidth-1:0] now_t       = '0;

  button_click_hold_gesture_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 time unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function void note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("mismatch in %s: expected %0h, got %0h", what, exp_val, act_val);
    end
  endfunction

  function void note_mismatch_if(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) note_mismatch(what, exp_val, act_val);
  endfunction

  task automatic reset_gesture_model();
    last_raw_lvl = 1'b0;
    raw_change_t = '0;
    stable_lvl   = 1'b0;
    press_t0     = '0;
    hold_seen    = 1'b0;
    muted        = 1'b0;
    cfg_debounce = DebounceMsReset;
    cfg_hold     = HoldMsReset;
  endtask

  // one sample through the debounce and gesture logic
  function automatic gesture_t predict_gesture(sample_t s);
    gesture_e ev;
    gesture_t res;
    ev = EV_NONE;
    // any raw change restarts the debounce window
    if (s.raw_pressed != last_raw_lvl) begin
      last_raw_lvl = s.raw_pressed;
      raw_change_t = s.now_ms;
    end
    // level held long enough: accept it, the differences wrap modulo 2^32
    if (TimeWidth'(s.now_ms - raw_change_t) >= TimeWidth'(cfg_debounce) &&
        s.raw_pressed != stable_lvl) begin
      stable_lvl = s.raw_pressed;
      if (stable_lvl) begin
        press_t0  = s.now_ms;
        hold_seen = 1'b0;
      end else if (hold_seen) begin
        ev = EV_HOLD_END;
      end else begin
        muted = ~muted;
      end
    end
    // one hold start per press, only while pressed
    if (stable_lvl && !hold_seen &&
        TimeWidth'(s.now_ms - press_t0) >= TimeWidth'(cfg_hold)) begin
      hold_seen = 1'b1;
      ev        = EV_HOLD_START;
    end
    res.gesture_event  = ev;
    res.mute_on        = muted;
    res.pressed_stable = stable_lvl;
    return res;
  endfunction

  // one apb transaction: setup cycle, then access until pready
  task automatic apb_access(input bit wr, input reg_idx_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done  = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, mirror it locally and read it back
  task automatic set_register(reg_idx_e idx, logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    if (idx == REG_DEBOUNCE_MS) cfg_debounce = value[CfgWidth-1:0];
    else cfg_hold = value[CfgWidth-1:0];
    apb_access(1'b0, idx, '0, rd);
    note_mismatch_if(idx == REG_DEBOUNCE_MS ? "debounce_ms readback" : "hold_ms readback",
                     {16'd0, value[CfgWidth-1:0]}, rd);
  endtask

  // drive one sample transaction and hold it until accepted
  task automatic send_sample(logic raw, logic [TimeWidth-1:0] t);
    int unsigned gap;
    bit          taken;
    sample_t     s;
    gap = pick_gap(gaps_on);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s.raw_pressed = raw;
    s.now_ms      = t;
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    gesture_q.push_back(predict_gesture(s));
    items_sent++;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // sender pauses until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side stall, random runs of stall cycles
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b1);
    end
  end

  // result checker: stall is stable from the negedge, so the transaction
  // completing at the next rising edge is known here
  always @(negedge clk_i) begin
    gesture_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gesture_q.size() == 0) begin
        note_mismatch("result with nothing pending", '0, 32'(out_data_o));
      end else begin
        want = gesture_q.pop_front();
        note_mismatch_if("gesture_event", 32'(want.gesture_event),
                         32'(out_data_o.gesture_event));
        note_mismatch_if("mute_on", 32'(want.mute_on), 32'(out_data_o.mute_on));
        note_mismatch_if("pressed_stable", 32'(want.pressed_stable),
                         32'(out_data_o.pressed_stable));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random stimulus pieces
  // ---------------------------------------------------------------------------

  // contact bounce: short toggles that never outlast the debounce time
  task automatic bounce_into(logic level);
    int unsigned k;
    int unsigned d;
    d = cfg_debounce;
    k = $urandom_range(0, 3);
    repeat (2 * k) begin
      now_t += (d == 0) ? 0 : $urandom_range(0, d - 1);
      send_sample(level, now_t);
      level = ~level;
    end
  endtask

  // a steady level spread over n samples covering dur ms
  task automatic level_run(logic level, int unsigned dur, int unsigned n);
    int unsigned step;
    step = dur / n;
    for (int unsigned i = 0; i < n; i++) begin
      now_t += step;
      if (i == n - 1) now_t += dur % n;
      send_sample(level, now_t);
    end
  endtask

  task automatic noise_burst();
    int unsigned d;
    int unsigned h;
    d = cfg_debounce;
    h = cfg_hold;
    repeat ($urandom_range(1, 5)) begin
      // sometimes a jump anywhere, forward or backward
      if ($urandom_range(0, 7) == 0) now_t = $urandom;
      else now_t += $urandom_range(0, d + h + 2);
      send_sample(1'($urandom_range(0, 1)), now_t);
    end
  endtask

  // press and release with bounce (a click, a hold, or a press cut short), or a burst of noise
  task automatic gesture_sequence();
    int unsigned d;
    int unsigned h;
    int unsigned kind;
    int unsigned dur;
    d    = cfg_debounce;
    h    = cfg_hold;
    kind = $urandom_range(0, 9);
    if (kind >= 6 && kind <= 7) begin
      noise_burst();
      return;
    end
    bounce_into(1'b1);
    if ($urandom_range(0, 1) == 0) dur = $urandom_range(d, d + h);
    else dur = $urandom_range(d + h, d + 2 * h + 10);
    if (kind >= 8) dur = $urandom_range(0, d + h);
    level_run(1'b1, dur, $urandom_range(1, 5));
    if (kind >= 8) return;
    bounce_into(1'b0);
    level_run(1'b0, $urandom_range(d, 2 * d + 5), $urandom_range(1, 3));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_register_reset();
    logic [31:0] rd;
    apb_access(1'b0, REG_DEBOUNCE_MS, '0, rd);
    note_mismatch_if("debounce_ms after reset", 32'(DebounceMsReset), rd);
    apb_access(1'b0, REG_HOLD_MS, '0, rd);
    note_mismatch_if("hold_ms after reset", 32'(HoldMsReset), rd);
  endtask

  // short press toggles mute on release
  task automatic test_click();
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd130);
    send_sample(1'b0, 32'd200);
    send_sample(1'b0, 32'd230);
  endtask

  // hold start exactly at the hold time, hold end on release
  task automatic test_hold();
    send_sample(1'b1, 32'd1000);
    send_sample(1'b1, 32'd1030);
    send_sample(1'b1, 32'd2029);
    send_sample(1'b1, 32'd2030);
    send_sample(1'b0, 32'd2100);
    send_sample(1'b0, 32'd2130);
  endtask

  // glitches restart the debounce window, one ms short is not enough
  task automatic test_bounce();
    send_sample(1'b1, 32'd3000);
    send_sample(1'b0, 32'd3010);
    send_sample(1'b1, 32'd3020);
    send_sample(1'b1, 32'd3049);
    send_sample(1'b1, 32'd3050);
    send_sample(1'b0, 32'd3100);
    send_sample(1'b0, 32'd3130);
  endtask

  // debounce across the 2^32 wrap, a backward step that looks like a long hold
  task automatic test_wrap();
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_000E);
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_001D);
  endtask

  // zero times: level taken at once, hold start with the press edge
  task automatic test_zero_times();
    drain_results();
    set_register(REG_DEBOUNCE_MS, 32'd0);
    set_register(REG_HOLD_MS, 32'd0);
    send_sample(1'b1, 32'd5000);
    send_sample(1'b0, 32'd5001);
  endtask

  task automatic test_max_times();
    drain_results();
    set_register(REG_DEBOUNCE_MS, 32'hFFFF);
    set_register(REG_HOLD_MS, 32'hFFFF);
    send_sample(1'b1, 32'd10000);
    send_sample(1'b1, 32'd10000 + 32'd65534);
    send_sample(1'b1, 32'd10000 + 32'd65535);
    send_sample(1'b0, 32'd10000 + 32'd131070);
  endtask

  // random gestures under several register settings and idling modes
  task automatic test_random_gestures();
    int unsigned goal;
    for (int p = 0; p < 6; p++) begin
      drain_results();
      case (p)
        0: begin
          gaps_on = 1'b1; stalls_on = 1'b1;
          set_register(REG_DEBOUNCE_MS, $urandom_range(0, 40));
          set_register(REG_HOLD_MS, $urandom_range(0, 300));
        end
        1: begin
          // full rate stretch, no idling on either side
          gaps_on = 1'b0; stalls_on = 1'b0;
          set_register(REG_DEBOUNCE_MS, 32'd0);
          set_register(REG_HOLD_MS, 32'd0);
        end
        2: begin
          // upper data bits set: only the low 16 bits count
          gaps_on = 1'b1; stalls_on = 1'b1;
          set_register(REG_DEBOUNCE_MS, {16'($urandom), 16'hFFFF});
          set_register(REG_HOLD_MS, {16'($urandom), 16'hFFFF});
        end
        3: begin
          set_register(REG_DEBOUNCE_MS, $urandom);
          set_register(REG_HOLD_MS, $urandom);
        end
        4: begin
          gaps_on = 1'b1; stalls_on = 1'b0;
          set_register(REG_DEBOUNCE_MS, 32'd1);
          set_register(REG_HOLD_MS, 32'd1);
        end
        default: begin
          gaps_on = 1'b0; stalls_on = 1'b1;
          set_register(REG_DEBOUNCE_MS, $urandom_range(0, 20));
          set_register(REG_HOLD_MS, $urandom_range(0, 100));
        end
      endcase
      now_t = $urandom;
      goal  = items_sent + PhaseItems;
      while (items_sent < goal) gesture_sequence();
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    reset_gesture_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_click();
    test_hold();
    test_bounce();
    test_wrap();
    test_zero_times();
    test_max_times();
    test_random_gestures();

    // let every owed result come back before the final check
    drain_results();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && gesture_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[button_click_hold_gesture_top.f]
rtl/core/bchg_pkg.sv
rtl/core/button_click_hold_gesture_top.sv
sim/testbench.sv
